// File: rtl/bcaf_pkg.sv
// shared types, op table and constants for the bezier flattener
`timescale 1ns / 1ps
package bcaf_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_W      = 36;
  localparam int LVL_W      = 3;
  localparam int NUM_OPS    = 19;
  localparam int STEP_W     = 5;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ERROR = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_DEPTH = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POP, ST_LOAD, ST_MUL_GO, ST_MUL_WAIT, ST_DECIDE,
    ST_EMIT_B, ST_EMIT_C, ST_EMIT_D, ST_SPLIT_R, ST_SPLIT_L, ST_FLUSH
  } state_t;

  typedef enum logic [3:0] {
    OP_HX, OP_HY, OP_UBX, OP_UBY, OP_UCX, OP_UCY, OP_L2X, OP_L2Y,
    OP_L3X, OP_L3Y, OP_C1, OP_C2, OP_FK, OP_LEN
  } opnd_t;

  typedef enum logic [3:0] {
    D_LEN, D_LEG1, D_LEG2, D_LEG3, D_C1, D_C2, D_CC1, D_CC2, D_THR, D_D1, D_D2
  } dst_t;

  typedef struct packed {
    opnd_t src_a;
    opnd_t src_b;
    dst_t  dst;
    logic  acc;
    logic  sub;
  } op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // one multiply per step, optionally accumulated into the destination
  function automatic op_t op_desc(input logic [STEP_W-1:0] step);
    op_t o;
    o = '{OP_HX, OP_HX, D_LEN, 1'b0, 1'b0};
    case (step)
      5'd0:  o = '{OP_HX,  OP_HX,  D_LEN,  1'b0, 1'b0};
      5'd1:  o = '{OP_HY,  OP_HY,  D_LEN,  1'b1, 1'b0};
      5'd2:  o = '{OP_UBX, OP_UBX, D_LEG1, 1'b0, 1'b0};
      5'd3:  o = '{OP_UBY, OP_UBY, D_LEG1, 1'b1, 1'b0};
      5'd4:  o = '{OP_L2X, OP_L2X, D_LEG2, 1'b0, 1'b0};
      5'd5:  o = '{OP_L2Y, OP_L2Y, D_LEG2, 1'b1, 1'b0};
      5'd6:  o = '{OP_L3X, OP_L3X, D_LEG3, 1'b0, 1'b0};
      5'd7:  o = '{OP_L3Y, OP_L3Y, D_LEG3, 1'b1, 1'b0};
      5'd8:  o = '{OP_HX,  OP_UBY, D_C1,   1'b0, 1'b0};
      5'd9:  o = '{OP_HY,  OP_UBX, D_C1,   1'b1, 1'b1};
      5'd10: o = '{OP_HX,  OP_UCY, D_C2,   1'b0, 1'b0};
      5'd11: o = '{OP_HY,  OP_UCX, D_C2,   1'b1, 1'b1};
      5'd12: o = '{OP_C1,  OP_C1,  D_CC1,  1'b0, 1'b0};
      5'd13: o = '{OP_C2,  OP_C2,  D_CC2,  1'b0, 1'b0};
      5'd14: o = '{OP_FK,  OP_LEN, D_THR,  1'b0, 1'b0};
      5'd15: o = '{OP_UBX, OP_HX,  D_D1,   1'b0, 1'b0};
      5'd16: o = '{OP_UBY, OP_HY,  D_D1,   1'b1, 1'b0};
      5'd17: o = '{OP_UCX, OP_HX,  D_D2,   1'b0, 1'b0};
      5'd18: o = '{OP_UCY, OP_HY,  D_D2,   1'b1, 1'b0};
      default: o = '{OP_HX, OP_HX, D_LEN, 1'b0, 1'b0};
    endcase
    return o;
  endfunction

endpackage

// File: rtl/bcaf_intf.sv
// channel interfaces: curve input, vertex output, register writes
`timescale 1ns / 1ps
interface bcaf_curve_if #(parameter int CW = 24) ();
  logic valid;
  logic ready;
  logic signed [CW-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
  modport source(output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                 input ready);
  modport sink(input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
               output ready);
endinterface

interface bcaf_vertex_if ();
  logic valid;
  logic ready;
  logic signed [35:0] pt_x;
  logic signed [35:0] pt_y;
  logic last;
  modport source(output valid, pt_x, pt_y, last, input ready);
  modport sink(input valid, pt_x, pt_y, last, output ready);
endinterface

interface bcaf_cfg_if ();
  logic valid;
  logic ready;
  logic [1:0]  addr;
  logic [15:0] data;
  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

// File: rtl/bcaf_mul.sv
// sequential signed multiplier, eight bits of the multiplier per cycle
`timescale 1ns / 1ps
module bcaf_mul #(
  parameter int W = 76
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [W-1:0]     a,
  input  logic signed [W-1:0]     b,
  output bcaf_pkg::mul_stat_t     stat,
  output logic signed [2*W-1:0]   prod
);
  import bcaf_pkg::*;

  localparam int ND = (W + 7) / 8;
  localparam int BW = ND * 8;
  localparam int PW = 2 * W;
  localparam int CNTW = $clog2(ND);

  logic [W-1:0]    ma;
  logic [BW-1:0]   mb;
  logic            neg;
  logic [PW-1:0]   acc;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done;
  logic [W+7:0]    pp;

  // msb digit first: shift the partial sum up and add the next row
  assign pp = ma * mb[BW-1 -: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(ND - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[W-1] ? W'(-a) : W'(a);
      mb  <= {{(BW-W){1'b0}}, (b[W-1] ? W'(-b) : W'(b))};
      neg <= a[W-1] ^ b[W-1];
      acc <= '0;
    end else if (busy) begin
      acc <= {acc[PW-9:0], 8'b0} + PW'(pp);
      mb  <= mb << 8;
    end
  end

  assign prod = neg ? -$signed(acc) : $signed(acc);
  assign stat = '{busy: busy, done: done};

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy)
    else $error("multiplier done without a run");

  property p_no_restart;
    @(posedge clk) disable iff (rst) start |-> !busy;
  endproperty
  a_no_restart: assert property (p_no_restart)
    else $error("multiplier started while busy");

  property p_busy_stops;
    @(posedge clk) disable iff (rst) done |-> !busy;
  endproperty
  a_busy_stops: assert property (p_busy_stops)
    else $error("multiplier busy after done");

endmodule

// File: rtl/bcaf_stack.sv
// piece stack: synchronous single-port-write memory, registered read
`timescale 1ns / 1ps
module bcaf_stack #(
  parameter int W     = 291,
  parameter int DEPTH = 5,
  parameter int AW    = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/cubic_bezier_adaptive_flatten_unit.sv
// top level: stack sequencer, test arithmetic, vertex output
//
// channel  dir  transfer when         payload
// cfg      in   cfg.valid & ready     addr (0 max_error, 1 max_depth), data
// curve    in   curve.valid & ready   p0..p3 x/y, signed Q15.8
// vertex   out  vertex.valid & ready  pt_x, pt_y (Q15.20), last
//
// each piece: pop, load, 19 wide multiplies on one shared multiplier and a decide
// state; a split adds two push states (right half, then left), an emit one state
// per vertex (one or three).
// rst is synchronous; the stack needs no clearing, every entry is written first.
// curve is taken only when the previous curve is done; a stalled vertex
// channel halts the sequencer at the next vertex to send.
`timescale 1ns / 1ps
module cubic_bezier_adaptive_flatten_unit #(
  parameter int MAX_DEPTH   = 4,
  parameter int COORD_WIDTH = 24
) (
  input  logic               clk,
  input  logic               rst,
  bcaf_cfg_if.sink           cfg,
  bcaf_curve_if.sink         curve,
  bcaf_vertex_if.source      vertex
);
  import bcaf_pkg::*;

  localparam int CW    = COORD_WIDTH + 12;
  localparam int DW    = CW + 1;
  localparam int OPW   = 2 * DW + 2;
  localparam int PW    = 2 * OPW;
  localparam int DEPTH = MAX_DEPTH + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int EW    = 8 * CW + LVL_W;
  localparam logic signed [PW-1:0] ONE = PW'(1);

  // configuration
  logic [15:0]      max_error;
  logic [LVL_W-1:0] max_depth;
  logic [31:0]      e2;
  logic [LVL_W-1:0] limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_error <= 16'd64;
      max_depth <= 3'd4;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_MAX_ERROR: max_error <= cfg.data;
        REG_MAX_DEPTH: max_depth <= cfg.data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    e2 <= max_error * max_error;
  end

  assign limit = (max_depth < LVL_W'(MAX_DEPTH)) ? max_depth : LVL_W'(MAX_DEPTH);

  // sequencer state
  state_t            state, state_next;
  logic [TW-1:0]     top;
  logic [STEP_W-1:0] step;

  // current piece
  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
  logic [LVL_W-1:0]     lvl;
  logic signed [DW-1:0] hx, hy, ubx, uby, ucx, ucy, l2x, l2y, l3x, l3y;
  logic signed [PW-1:0] r_len, r_leg1, r_leg2, r_leg3, r_c1, r_c2;
  logic signed [PW-1:0] r_cc1, r_cc2, r_thr, r_d1, r_d2;

  // last emitted vertex, held back until the next one shows whether it is final
  logic signed [CW-1:0] pend_x, pend_y;

  // output register
  logic                 out_valid;
  logic signed [CW-1:0] out_x, out_y;
  logic                 out_last;
  logic                 out_free;

  // stack memory
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  bcaf_stack #(.W(EW), .DEPTH(DEPTH), .AW(AW)) u_stack (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // multiplier
  op_t                   op;
  logic                  mul_start;
  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [PW-1:0]  prod;
  mul_stat_t             mul_stat;

  bcaf_mul #(.W(OPW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .stat(mul_stat), .prod(prod)
  );

  assign op = op_desc(step);

  function automatic logic signed [OPW-1:0] pick(input opnd_t s,
      input logic signed [DW-1:0] vhx, vhy, vubx, vuby, vucx, vucy,
      input logic signed [DW-1:0] vl2x, vl2y, vl3x, vl3y,
      input logic signed [PW-1:0] vc1, vc2, vlen, input logic [31:0] ve2);
    logic signed [OPW-1:0] r;
    r = '0;
    case (s)
      OP_HX:  r = OPW'(vhx);
      OP_HY:  r = OPW'(vhy);
      OP_UBX: r = OPW'(vubx);
      OP_UBY: r = OPW'(vuby);
      OP_UCX: r = OPW'(vucx);
      OP_UCY: r = OPW'(vucy);
      OP_L2X: r = OPW'(vl2x);
      OP_L2Y: r = OPW'(vl2y);
      OP_L3X: r = OPW'(vl3x);
      OP_L3Y: r = OPW'(vl3y);
      OP_C1:  r = vc1[OPW-1:0];
      OP_C2:  r = vc2[OPW-1:0];
      OP_FK:  r = $signed(OPW'({ve2, 26'b0}));
      OP_LEN: r = vlen[OPW-1:0];
      default: r = '0;
    endcase
    return r;
  endfunction

  assign mul_a = pick(op.src_a, hx, hy, ubx, uby, ucx, ucy, l2x, l2y, l3x, l3y,
                      r_c1, r_c2, r_len, e2);
  assign mul_b = pick(op.src_b, hx, hy, ubx, uby, ucx, ucy, l2x, l2y, l3x, l3y,
                      r_c1, r_c2, r_len, e2);

  function automatic logic signed [CW-1:0] mid(input logic signed [CW-1:0] p, q);
    logic signed [CW:0] s;
    s = {p[CW-1], p} + {q[CW-1], q};
    return s[CW:1];
  endfunction

  // de casteljau split at one half
  logic signed [CW-1:0] abx, aby, bcx, bcy, cdx, cdy, lx, ly, rx, ry, mx, my;
  assign abx = mid(ax, bx);
  assign aby = mid(ay, by);
  assign bcx = mid(bx, cx);
  assign bcy = mid(by, cy);
  assign cdx = mid(cx, dx);
  assign cdy = mid(cy, dy);
  assign lx  = mid(abx, bcx);
  assign ly  = mid(aby, bcy);
  assign rx  = mid(bcx, cdx);
  assign ry  = mid(bcy, cdy);
  assign mx  = mid(lx, rx);
  assign my  = mid(ly, ry);

  // piece tests
  logic signed [PW-1:0] short_k;
  logic near, legs_tiny, at_lim, flat, tiny;
  assign short_k   = $signed(PW'({e2, 22'b0}));
  assign near      = r_len <= ONE;
  assign legs_tiny = (r_leg1 <= ONE) && (r_leg2 <= ONE) && (r_leg3 <= ONE);
  assign at_lim    = lvl >= limit;
  assign flat      = (r_cc1 <= r_thr) && (r_cc2 <= r_thr) &&
                     !r_d1[PW-1] && (r_d1 <= r_len) && !r_d2[PW-1] && (r_d2 <= r_len);
  assign tiny      = (r_len <= short_k) && (r_leg1 <= short_k) &&
                     (r_leg2 <= short_k) && (r_leg3 <= short_k);

  // vertex candidate
  logic signed [CW-1:0] cand_x, cand_y;
  logic dup;
  always_comb begin
    case (state)
      ST_EMIT_B: begin cand_x = bx; cand_y = by; end
      ST_EMIT_C: begin cand_x = cx; cand_y = cy; end
      default:   begin cand_x = dx; cand_y = dy; end
    endcase
  end
  assign dup      = (cand_x == pend_x) && (cand_y == pend_y);
  assign out_free = !out_valid || vertex.ready;

  logic curve_take;
  assign curve_take = curve.valid && curve.ready;

  logic signed [CW-1:0] in0x, in0y, in1x, in1y, in2x, in2y, in3x, in3y;
  assign in0x = {curve.p0_x[COORD_WIDTH-1:0], 12'b0};
  assign in0y = {curve.p0_y[COORD_WIDTH-1:0], 12'b0};
  assign in1x = {curve.p1_x[COORD_WIDTH-1:0], 12'b0};
  assign in1y = {curve.p1_y[COORD_WIDTH-1:0], 12'b0};
  assign in2x = {curve.p2_x[COORD_WIDTH-1:0], 12'b0};
  assign in2y = {curve.p2_y[COORD_WIDTH-1:0], 12'b0};
  assign in3x = {curve.p3_x[COORD_WIDTH-1:0], 12'b0};
  assign in3y = {curve.p3_y[COORD_WIDTH-1:0], 12'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    curve.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = top[AW-1:0];
    mem_wdata   = {lvl + 1'b1, dy, dx, cdy, cdx, ry, rx, my, mx};
    mem_re      = 1'b0;
    mem_raddr   = AW'(top - 1'b1);
    mul_start   = 1'b0;
    case (state)
      ST_IDLE: begin
        curve.ready = 1'b1;
        mem_waddr   = '0;
        mem_wdata   = {LVL_W'(0), in3y, in3x, in2y, in2x, in1y, in1x, in0y, in0x};
        if (curve.valid) begin
          mem_we     = 1'b1;
          state_next = ST_POP;
        end
      end
      ST_POP: begin
        if (top == '0) begin
          state_next = ST_FLUSH;
        end else begin
          mem_re     = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:  state_next = ST_MUL_GO;
      ST_MUL_GO: begin
        mul_start  = 1'b1;
        state_next = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_stat.done) begin
          state_next = (step == STEP_W'(NUM_OPS - 1)) ? ST_DECIDE : ST_MUL_GO;
        end
      end
      ST_DECIDE: begin
        if (near) begin
          if (legs_tiny)   state_next = ST_EMIT_D;
          else if (at_lim) state_next = ST_EMIT_B;
          else             state_next = ST_SPLIT_R;
        end else if (flat || at_lim || tiny) begin
          state_next = ST_EMIT_D;
        end else begin
          state_next = ST_SPLIT_R;
        end
      end
      ST_EMIT_B: if (dup || out_free) state_next = ST_EMIT_C;
      ST_EMIT_C: if (dup || out_free) state_next = ST_EMIT_D;
      ST_EMIT_D: if (dup || out_free) state_next = ST_POP;
      ST_SPLIT_R: begin
        mem_we     = 1'b1;
        state_next = ST_SPLIT_L;
      end
      ST_SPLIT_L: begin
        mem_we     = 1'b1;
        mem_wdata  = {lvl + 1'b1, my, mx, ly, lx, aby, abx, ay, ax};
        state_next = ST_POP;
      end
      ST_FLUSH: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // stack pointer and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      top  <= '0;
      step <= '0;
    end else begin
      case (state)
        ST_IDLE:    if (curve.valid) top <= TW'(1);
        ST_POP:     if (top != '0) top <= top - 1'b1;
        ST_SPLIT_R: top <= top + 1'b1;
        ST_SPLIT_L: top <= top + 1'b1;
        default: ;
      endcase
      if (state == ST_LOAD) begin
        step <= '0;
      end else if (state == ST_MUL_WAIT && mul_stat.done) begin
        step <= step + 1'b1;
      end
    end
  end

  // piece registers
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      ax  <= mem_rdata[0*CW +: CW];
      ay  <= mem_rdata[1*CW +: CW];
      bx  <= mem_rdata[2*CW +: CW];
      by  <= mem_rdata[3*CW +: CW];
      cx  <= mem_rdata[4*CW +: CW];
      cy  <= mem_rdata[5*CW +: CW];
      dx  <= mem_rdata[6*CW +: CW];
      dy  <= mem_rdata[7*CW +: CW];
      lvl <= mem_rdata[8*CW +: LVL_W];
      hx  <= DW'($signed(mem_rdata[6*CW +: CW])) - DW'($signed(mem_rdata[0*CW +: CW]));
      hy  <= DW'($signed(mem_rdata[7*CW +: CW])) - DW'($signed(mem_rdata[1*CW +: CW]));
      ubx <= DW'($signed(mem_rdata[2*CW +: CW])) - DW'($signed(mem_rdata[0*CW +: CW]));
      uby <= DW'($signed(mem_rdata[3*CW +: CW])) - DW'($signed(mem_rdata[1*CW +: CW]));
      ucx <= DW'($signed(mem_rdata[4*CW +: CW])) - DW'($signed(mem_rdata[0*CW +: CW]));
      ucy <= DW'($signed(mem_rdata[5*CW +: CW])) - DW'($signed(mem_rdata[1*CW +: CW]));
      l2x <= DW'($signed(mem_rdata[4*CW +: CW])) - DW'($signed(mem_rdata[2*CW +: CW]));
      l2y <= DW'($signed(mem_rdata[5*CW +: CW])) - DW'($signed(mem_rdata[3*CW +: CW]));
      l3x <= DW'($signed(mem_rdata[6*CW +: CW])) - DW'($signed(mem_rdata[4*CW +: CW]));
      l3y <= DW'($signed(mem_rdata[7*CW +: CW])) - DW'($signed(mem_rdata[5*CW +: CW]));
    end
  end

  // accumulate products into the test terms
  logic signed [PW-1:0] cur, upd;
  always_comb begin
    case (op.dst)
      D_LEN:  cur = r_len;
      D_LEG1: cur = r_leg1;
      D_LEG2: cur = r_leg2;
      D_LEG3: cur = r_leg3;
      D_C1:   cur = r_c1;
      D_C2:   cur = r_c2;
      D_CC1:  cur = r_cc1;
      D_CC2:  cur = r_cc2;
      D_THR:  cur = r_thr;
      D_D1:   cur = r_d1;
      D_D2:   cur = r_d2;
      default: cur = '0;
    endcase
    if (!op.acc)     upd = prod;
    else if (op.sub) upd = cur - prod;
    else             upd = cur + prod;
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL_WAIT && mul_stat.done) begin
      case (op.dst)
        D_LEN:  r_len  <= upd;
        D_LEG1: r_leg1 <= upd;
        D_LEG2: r_leg2 <= upd;
        D_LEG3: r_leg3 <= upd;
        D_C1:   r_c1   <= upd;
        D_C2:   r_c2   <= upd;
        D_CC1:  r_cc1  <= upd;
        D_CC2:  r_cc2  <= upd;
        D_THR:  r_thr  <= upd;
        D_D1:   r_d1   <= upd;
        D_D2:   r_d2   <= upd;
        default: ;
      endcase
    end
  end

  // vertex path: pending vertex, then output register
  logic emit_send;
  assign emit_send = (state == ST_EMIT_B || state == ST_EMIT_C || state == ST_EMIT_D)
                     && !dup && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_x    <= '0;
      pend_y    <= '0;
    end else begin
      if (emit_send || (state == ST_FLUSH && out_free)) begin
        out_valid <= 1'b1;
      end else if (vertex.ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_IDLE && curve_take) begin
        pend_x <= in0x;
        pend_y <= in0y;
      end else if (emit_send) begin
        pend_x <= cand_x;
        pend_y <= cand_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_send || (state == ST_FLUSH && out_free)) begin
      out_x    <= pend_x;
      out_y    <= pend_y;
      out_last <= (state == ST_FLUSH);
    end
  end

  assign vertex.valid = out_valid;
  assign vertex.pt_x  = OUT_W'(out_x);
  assign vertex.pt_y  = OUT_W'(out_y);
  assign vertex.last  = out_last;

  property p_top_bound;
    @(posedge clk) disable iff (rst) top <= TW'(DEPTH);
  endproperty
  a_top_bound: assert property (p_top_bound)
    else $error("stack pointer past depth");

  property p_root_push;
    @(posedge clk) disable iff (rst) curve_take |=> (top == TW'(1)) && (state == ST_POP);
  endproperty
  a_root_push: assert property (p_root_push)
    else $error("root piece not pushed on curve transfer");

  property p_level_bound;
    @(posedge clk) disable iff (rst) state == ST_DECIDE |-> lvl <= LVL_W'(MAX_DEPTH);
  endproperty
  a_level_bound: assert property (p_level_bound)
    else $error("piece level beyond depth limit");

  property p_no_mem_clash;
    @(posedge clk) disable iff (rst) state == ST_LOAD |-> $past(mem_re) && !$past(mem_we);
  endproperty
  a_no_mem_clash: assert property (p_no_mem_clash)
    else $error("stack load without a clean read");

endmodule

// File: verif/tb_cubic_bezier_adaptive_flatten_unit.sv
// testbench for the cubic bezier flattener: predicted polyline vs. vertex stream
`timescale 1ns / 1ps
module tb_cubic_bezier_adaptive_flatten_unit;
  import bcaf_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef logic [7:0][23:0] curve_t;

  typedef struct {
    logic [35:0] x;
    logic [35:0] y;
    logic        last;
  } vertex_t;

  class polyline_scoreboard;
    logic [15:0] max_error;
    logic [2:0]  max_depth;
    vertex_t     expected_vertices[$];
    vertex_t     curve_pts[$];
    int          mismatches;
    longint      prev_x, prev_y;

    function new();
      max_error = 16'd64;
      max_depth = 3'd4;
      mismatches = 0;
      prev_x = 0;
      prev_y = 0;
    endfunction

    function void set_reg(logic [1:0] addr, logic [15:0] data);
      if (addr == REG_MAX_ERROR) max_error = data;
      else if (addr == REG_MAX_DEPTH) max_depth = data[2:0];
    endfunction

    function void add_point(longint x, longint y);
      vertex_t v;
      if (curve_pts.size() > 0 && x == prev_x && y == prev_y) return;
      if (curve_pts.size() >= 49) return;
      v.x = x[35:0];
      v.y = y[35:0];
      v.last = 1'b0;
      prev_x = x;
      prev_y = y;
      curve_pts = {curve_pts, v};
    endfunction

    // depth-first de casteljau flattening, stack of five pieces
    function void note_curve(curve_t c);
      longint sa_x[5], sa_y[5], sb_x[5], sb_y[5], sc_x[5], sc_y[5], sd_x[5], sd_y[5];
      int     s_lvl[5];
      longint p[8];
      longint ax, ay, bx, by, cx, cy, dx, dy;
      longint abx, aby, bcx, bcy, cdx, cdy, lx, ly, rx, ry, mx, my;
      wide_t  hx, hy, ubx, uby, ucx, ucy, l2x, l2y, l3x, l3y;
      wide_t  len, leg1, leg2, leg3, thr, c1, c2, d1, d2, fk, sk;
      longint e2;
      int     top, i, lvl, lim;
      bit     flat, done;
      lim = (max_depth < 4) ? max_depth : 4;
      e2 = longint'(max_error) * longint'(max_error);
      fk = wide_t'(e2 <<< 26);
      sk = wide_t'(e2 <<< 22);
      for (int k = 0; k < 8; k++) p[k] = longint'($signed(c[k])) * 4096;
      curve_pts.delete();
      add_point(p[0], p[1]);
      sa_x[0] = p[0]; sa_y[0] = p[1]; sb_x[0] = p[2]; sb_y[0] = p[3];
      sc_x[0] = p[4]; sc_y[0] = p[5]; sd_x[0] = p[6]; sd_y[0] = p[7];
      s_lvl[0] = 0;
      top = 1;
      while (top > 0) begin
        i = top - 1;
        ax = sa_x[i]; ay = sa_y[i]; bx = sb_x[i]; by = sb_y[i];
        cx = sc_x[i]; cy = sc_y[i]; dx = sd_x[i]; dy = sd_y[i];
        lvl = s_lvl[i];
        top = i;
        hx = wide_t'(dx - ax);  hy = wide_t'(dy - ay);
        ubx = wide_t'(bx - ax); uby = wide_t'(by - ay);
        ucx = wide_t'(cx - ax); ucy = wide_t'(cy - ay);
        l2x = wide_t'(cx - bx); l2y = wide_t'(cy - by);
        l3x = wide_t'(dx - cx); l3y = wide_t'(dy - cy);
        len = hx * hx + hy * hy;
        leg1 = ubx * ubx + uby * uby;
        leg2 = l2x * l2x + l2y * l2y;
        leg3 = l3x * l3x + l3y * l3y;
        done = 0;
        if (len <= 1) begin
          // degenerate chord: the control legs and the level limit decide
          if (leg1 <= 1 && leg2 <= 1 && leg3 <= 1) begin
            add_point(dx, dy);
            done = 1;
          end else if (lvl >= lim) begin
            add_point(bx, by);
            add_point(cx, cy);
            add_point(dx, dy);
            done = 1;
          end
        end else begin
          thr = fk * len;
          c1 = hx * uby - hy * ubx;
          c2 = hx * ucy - hy * ucx;
          flat = (c1 * c1 <= thr) && (c2 * c2 <= thr);
          if (flat) begin
            d1 = ubx * hx + uby * hy;
            d2 = ucx * hx + ucy * hy;
            if (d1 < 0 || d1 > len || d2 < 0 || d2 > len) flat = 0;
          end
          if (flat || lvl >= lim) begin
            add_point(dx, dy);
            done = 1;
          end else if (len <= sk && leg1 <= sk && leg2 <= sk && leg3 <= sk) begin
            add_point(dx, dy);
            done = 1;
          end
        end
        if (!done) begin
          abx = (ax + bx) >>> 1; aby = (ay + by) >>> 1;
          bcx = (bx + cx) >>> 1; bcy = (by + cy) >>> 1;
          cdx = (cx + dx) >>> 1; cdy = (cy + dy) >>> 1;
          lx = (abx + bcx) >>> 1; ly = (aby + bcy) >>> 1;
          rx = (bcx + cdx) >>> 1; ry = (bcy + cdy) >>> 1;
          mx = (lx + rx) >>> 1;   my = (ly + ry) >>> 1;
          if (top < 5) begin
            sa_x[top] = mx; sa_y[top] = my; sb_x[top] = rx; sb_y[top] = ry;
            sc_x[top] = cdx; sc_y[top] = cdy; sd_x[top] = dx; sd_y[top] = dy;
            s_lvl[top] = lvl + 1;
            top++;
          end
          if (top < 5) begin
            sa_x[top] = ax; sa_y[top] = ay; sb_x[top] = abx; sb_y[top] = aby;
            sc_x[top] = lx; sc_y[top] = ly; sd_x[top] = mx; sd_y[top] = my;
            s_lvl[top] = lvl + 1;
            top++;
          end
        end
      end
      curve_pts[curve_pts.size() - 1].last = 1'b1;
      expected_vertices = {expected_vertices, curve_pts};
    endfunction

    function void check_vertex(logic [35:0] x, logic [35:0] y, logic last);
      vertex_t e;
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex x=%h y=%h last=%b", x, y, last);
        return;
      end
      e = expected_vertices.pop_front();
      if (e.x !== x || e.y !== y || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("vertex mismatch: expected x=%h y=%h last=%b, got x=%h y=%h last=%b",
                   e.x, e.y, e.last, x, y, last);
      end
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   no_idle;
  polyline_scoreboard sb;

  bcaf_cfg_if cfg_ch ();
  bcaf_curve_if #(.CW(24)) crv ();
  bcaf_vertex_if vtx ();

  cubic_bezier_adaptive_flatten_unit #(.MAX_DEPTH(4), .COORD_WIDTH(24)) dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch), .curve(crv), .vertex(vtx)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 12);
  endfunction

  // leaves valid high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
    cfg_ch.addr <= addr;
    cfg_ch.data <= data;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
    sb.set_reg(addr, data);
  endtask

  task automatic send_curve(input curve_t c);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      crv.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    {crv.p3_y, crv.p3_x, crv.p2_y, crv.p2_x, crv.p1_y, crv.p1_x, crv.p0_y, crv.p0_x} <= c;
    crv.valid <= 1'b1;
    @(posedge clk);
    while (!(crv.valid && crv.ready)) @(posedge clk);
    sb.note_curve(c);
  endtask

  task automatic wait_drained();
    crv.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // point order in curve_t: p0x p0y p1x p1y p2x p2y p3x p3y
  function automatic curve_t make_curve(int x0, int y0, int x1, int y1,
                                        int x2, int y2, int x3, int y3);
    curve_t c;
    c[0] = x0[23:0]; c[1] = y0[23:0]; c[2] = x1[23:0]; c[3] = y1[23:0];
    c[4] = x2[23:0]; c[5] = y2[23:0]; c[6] = x3[23:0]; c[7] = y3[23:0];
    return c;
  endfunction

  function automatic curve_t random_curve();
    curve_t c;
    int kind, bx, by, span, k;
    kind = $urandom_range(0, 99);
    bx = $urandom;
    by = $urandom;
    span = 1 << $urandom_range(0, 14);
    for (k = 0; k < 8; k++) begin
      if (kind < 20) c[k] = 24'($urandom);
      else c[k] = 24'(((k % 2) ? by : bx) + $signed($urandom_range(0, 2 * span)) - span);
    end
    if (kind >= 70 && kind < 85) begin
      // closed loop: end point on the start point
      c[6] = c[0];
      c[7] = c[1];
    end else if (kind >= 85) begin
      // collinear controls along the chord
      c[2] = 24'($signed(c[0]) + ($signed(c[6]) - $signed(c[0])) / 3);
      c[3] = 24'($signed(c[1]) + ($signed(c[7]) - $signed(c[1])) / 3);
      c[4] = 24'($signed(c[0]) + 2 * ($signed(c[6]) - $signed(c[0])) / 3);
      c[5] = 24'($signed(c[1]) + 2 * ($signed(c[7]) - $signed(c[1])) / 3);
    end
    return c;
  endfunction

  // vertex side: random back-pressure, checks on every transfer
  initial begin
    int gap;
    vtx.ready <= 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        vtx.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      vtx.ready <= 1'b1;
      @(posedge clk);
      while (!(vtx.valid && vtx.ready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && vtx.valid && vtx.ready) sb.check_vertex(vtx.pt_x, vtx.pt_y, vtx.last);
  end

  initial begin
    #30000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [15:0] err_set[6];
    logic [2:0]  depth_set[6];
    sb = new();
    no_idle = 1'b0;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.addr <= '0;
    cfg_ch.data <= '0;
    crv.valid <= 1'b0;
    {crv.p3_y, crv.p3_x, crv.p2_y, crv.p2_x, crv.p1_y, crv.p1_x, crv.p0_y, crv.p0_x} <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed curves at the reset settings
    send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0));
    send_curve(make_curve(8388607, 8388607, 8388607, 8388607,
                          8388607, 8388607, 8388607, 8388607));
    send_curve(make_curve(-8388608, -8388608, 8388607, 8388607,
                          -8388608, 8388607, 8388607, -8388608));
    send_curve(make_curve(8388607, -8388608, -8388608, 8388607,
                          8388607, 8388607, -8388608, -8388608));
    send_curve(make_curve(100, 100, 5000, -3000, -4000, 7000, 100, 100));
    send_curve(make_curve(0, 0, 1000, 0, 2000, 0, 3000, 0));
    send_curve(make_curve(0, 0, -1000, 0, 4000, 0, 3000, 0));
    send_curve(make_curve(0, 0, 3, 5, 7, 2, 10, 9));
    send_curve(make_curve(50, 50, 50, 50, 50, 50, 51, 50));
    send_curve(make_curve(0, 0, 0, 25600, 25600, 25600, 25600, 0));
    send_curve(make_curve(-12345, 6789, 300, -40000, 90000, 1200, 20000, 20000));
    wait_drained();

    err_set   = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'd16, 16'd64};
    depth_set = '{3'd4, 3'd0, 3'd2, 3'd7, 3'd3, 3'd1};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MAX_ERROR, err_set[ph]);
      write_reg(REG_MAX_DEPTH, depth_set[ph]);
      cfg_ch.valid <= 1'b0;
      no_idle = (ph == 2);
      if (ph == 0) begin
        // zero error: only exactly straight pieces pass early
        send_curve(make_curve(0, 0, 100, 0, 200, 0, 300, 0));
        send_curve(make_curve(10, 10, 10, 900, 10, 10, 10, 10));
      end
      for (int n = 0; n < 27; n++) send_curve(random_curve());
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
